### rtl/tsq_pkg.sv
package tsq_pkg;

    // field widths of one command word and one response word
    localparam int unsigned OPCODE_W = 2;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned INDEX_W  = 5;
    localparam int unsigned COUNT_W  = 6;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CAP_W    = 5;

    // configuration register
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef logic [OPCODE_W-1:0] t_opcode;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_opcode OP_PUSH = 2'd0;
    localparam t_opcode OP_POP  = 2'd1;
    localparam t_opcode OP_READ = 2'd2;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_PUSH_FULL = 2'd1;
    localparam t_status ST_POP_EMPTY = 2'd2;
    localparam t_status ST_BAD_INDEX = 2'd3;

    // response fields other than the data word
    typedef struct packed {
        logic [COUNT_W-1:0] item_count;
        logic               is_full;
        t_status            status;
        logic               rd_hit;    // data word comes from the ring
    } t_rsp_meta;

endpackage

### rtl/tsq_if.sv
interface tsq_in_if import tsq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    t_opcode                   opcode;
    logic signed [VALUE_W-1:0] push_value;
    logic [INDEX_W-1:0]        read_index;

    modport source (output valid, output opcode, output push_value, output read_index,
                    input ready);
    modport sink   (input valid, input opcode, input push_value, input read_index,
                    output ready);
endinterface

interface tsq_out_if import tsq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] data_out;
    logic [COUNT_W-1:0]        item_count;
    logic                      is_full;
    t_status                   status;

    modport source (output valid, output data_out, output item_count, output is_full,
                    output status, input ready);
    modport sink   (input valid, input data_out, input item_count, input is_full,
                    input status, output ready);
endinterface

### rtl/two_stack_queue.sv
// FIFO queue modeled as two stacks (input and output), each limited to the
// stack_capacity register clamped to 1..STACK_DEPTH. Entries live in FIFO
// order in a ring of 2*STACK_DEPTH words, so moving the input stack across
// only changes two counts. Every command word (push, pop, indexed read from
// the oldest entry) gives exactly one response word with the data, the entry
// count after the command, the full flag and a status code. Throughput is one
// command per clock while responses drain; the response is registered and
// appears in the cycle after acceptance, from the ring's registered read
// port. The single response register backpressures the command side: a
// command is taken whenever that register is empty or is being drained in
// the same cycle. Write stack_capacity only while no command is in flight.
module two_stack_queue import tsq_pkg::*; #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tsq_in_if.sink             i_cmd,
    tsq_out_if.source          o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int unsigned RING = 2 * STACK_DEPTH;
    localparam int unsigned PW   = $clog2(RING);

    // register file: stack_capacity at byte address 0
    logic [CAP_W-1:0] r_capacity;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? 32'(r_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (cfg_wr) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    // handshake: one response slot, refilled in the cycle it drains
    logic r_out_valid;
    logic accept;

    assign i_cmd.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;

    logic          ram_we, ram_re;
    logic [PW-1:0] ram_waddr, ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;
    t_rsp_meta     meta;
    t_rsp_meta     r_meta;

    tsq_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_opcode     (i_cmd.opcode),
        .i_read_index (i_cmd.read_index),
        .i_capacity   (r_capacity),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_re     (ram_re),
        .o_ram_raddr  (ram_raddr),
        .o_meta       (meta)
    );

    // ring of queued words; read data register holds while the response stalls
    tsq_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (RING)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.push_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_meta <= meta;
        end
    end

    // data is zero on push, on errors and on an unused opcode
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.data_out   = r_meta.rd_hit ? ram_rdata : '0;
    assign o_rsp.item_count = r_meta.item_count;
    assign o_rsp.is_full    = r_meta.is_full;
    assign o_rsp.status     = r_meta.status;

endmodule

### rtl/tsq_ram.sv
module tsq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/tsq_ctrl.sv
module tsq_ctrl import tsq_pkg::*; #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  t_opcode                             i_opcode,
    input  logic [INDEX_W-1:0]                  i_read_index,
    input  logic [CAP_W-1:0]                    i_capacity,
    output logic                                o_ram_we,
    output logic [$clog2(2*STACK_DEPTH)-1:0]    o_ram_waddr,
    output logic                                o_ram_re,
    output logic [$clog2(2*STACK_DEPTH)-1:0]    o_ram_raddr,
    output t_rsp_meta                           o_meta
);

    localparam int unsigned RING = 2 * STACK_DEPTH;
    localparam int unsigned PW   = $clog2(RING);
    localparam int unsigned CW   = $clog2(STACK_DEPTH + 1);
    localparam int unsigned TW   = $clog2(RING + 1);
    localparam int unsigned CAPC = (CW > CAP_W) ? CW : CAP_W;
    localparam int unsigned CMPW = (TW > INDEX_W) ? TW : INDEX_W;
    localparam int unsigned SW   = ((PW > INDEX_W) ? PW : INDEX_W) + 1;

    logic [PW-1:0]   r_oldest, n_oldest;
    logic [CW-1:0]   r_in_cnt, n_in_cnt;
    logic [CW-1:0]   r_out_cnt, n_out_cnt;

    logic [CW-1:0]   cap_eff;
    logic [TW-1:0]   total, new_total;
    logic            in_at_cap, out_empty, full;
    logic [PW:0]     wsum;
    logic [PW-1:0]   tail_addr;
    logic [SW-1:0]   rsum;
    logic [PW-1:0]   idx_addr;
    logic            idx_ok;
    t_status         status;
    logic            re, we;
    logic [PW-1:0]   raddr;

    always_comb begin
        // clamp capacity to 1..STACK_DEPTH
        if (i_capacity == '0) begin
            cap_eff = CW'(1);
        end else if (CAPC'(i_capacity) > CAPC'(STACK_DEPTH)) begin
            cap_eff = CW'(STACK_DEPTH);
        end else begin
            cap_eff = CW'(i_capacity);
        end

        total     = TW'(r_in_cnt) + TW'(r_out_cnt);
        in_at_cap = r_in_cnt >= cap_eff;
        out_empty = r_out_cnt == '0;
        full      = in_at_cap && !out_empty;

        // ring addresses, each sum below twice the ring depth
        wsum      = (PW+1)'(r_oldest) + (PW+1)'(total);
        tail_addr = (wsum >= (PW+1)'(RING)) ? PW'(wsum - (PW+1)'(RING)) : PW'(wsum);
        rsum      = SW'(r_oldest) + SW'(i_read_index);
        idx_addr  = (rsum >= SW'(RING)) ? PW'(rsum - SW'(RING)) : PW'(rsum);
        idx_ok    = CMPW'(i_read_index) < CMPW'(total);

        n_oldest  = r_oldest;
        n_in_cnt  = r_in_cnt;
        n_out_cnt = r_out_cnt;
        status    = ST_OK;
        we        = 1'b0;
        re        = 1'b0;
        raddr     = r_oldest;

        case (i_opcode)
            OP_PUSH: begin
                if (full) begin
                    status = ST_PUSH_FULL;
                end else begin
                    // full input stack with empty output stack moves across first
                    if (in_at_cap) begin
                        n_out_cnt = r_in_cnt;
                        n_in_cnt  = CW'(1);
                    end else begin
                        n_in_cnt  = r_in_cnt + CW'(1);
                    end
                    we = 1'b1;
                end
            end
            OP_POP: begin
                if (total == '0) begin
                    status = ST_POP_EMPTY;
                end else begin
                    if (out_empty) begin
                        n_out_cnt = r_in_cnt - CW'(1);
                        n_in_cnt  = '0;
                    end else begin
                        n_out_cnt = r_out_cnt - CW'(1);
                    end
                    re       = 1'b1;
                    n_oldest = (r_oldest == PW'(RING - 1)) ? '0 : r_oldest + PW'(1);
                end
            end
            OP_READ: begin
                if (idx_ok) begin
                    re    = 1'b1;
                    raddr = idx_addr;
                end else begin
                    status = ST_BAD_INDEX;
                end
            end
            default: begin
                // unused opcode: no effect
            end
        endcase

        new_total         = TW'(n_in_cnt) + TW'(n_out_cnt);
        o_meta.item_count = COUNT_W'(new_total);
        o_meta.is_full    = (n_in_cnt >= cap_eff) && (n_out_cnt != '0);
        o_meta.status     = status;
        o_meta.rd_hit     = re;
    end

    assign o_ram_we    = i_accept && we;
    assign o_ram_waddr = tail_addr;
    assign o_ram_re    = i_accept && re;
    assign o_ram_raddr = raddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest  <= '0;
            r_in_cnt  <= '0;
            r_out_cnt <= '0;
        end else if (i_accept) begin
            r_oldest  <= n_oldest;
            r_in_cnt  <= n_in_cnt;
            r_out_cnt <= n_out_cnt;
        end
    end

endmodule
